// ----- rtl/core/modular_exponentiation_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the modular exponentiation core
// Clocked concurrent assertion wrappers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`define MODULAR_EXPONENTIATION_CORE_ASSERT_SVH

// Checked on every rising edge of aclk outside of reset.
`define MEXP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define MEXP_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/core/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants of the modular exponentiation core.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int unsigned FIELD_W = 32;
    localparam logic [FIELD_W-1:0] MODULUS_RESET = 32'd1000000007;

    // operand selection for the modular multiplier
    typedef enum logic [1:0] {
        OP_REDUCE = 2'd0,   // 1 * base, reduces the base
        OP_MUL    = 2'd1,   // result * square
        OP_SQR    = 2'd2    // square * square
    } mul_op_t;

    typedef struct packed {
        logic    load;
        logic    force_zero;
        logic    start;
        mul_op_t op;
        logic    wb_res;
        logic    wb_sq;
        logic    shift_exp;
        logic    publish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic m_small;
        logic exp_zero;
        logic exp_lsb;
        logic mul_done;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/core/mexp_modmul.sv -----
// ----------------------------------------------------------------------------
// mexp_modmul
// Bit-serial shift-add modular multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mexp_modmul #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] product
);

    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     a_reg;
    logic [W-1:0]     b_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [W-1:0]     dbl;

    // (x + y) mod m for x, y < m
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] x,
                                             input logic [W-1:0] y,
                                             input logic [W-1:0] md);
        logic [W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, md}) begin
            s = s - {1'b0, md};
        end
        return s[W-1:0];
    endfunction

    always_comb begin
        dbl      = add_mod(acc_reg, acc_reg, m);
        acc_next = b_reg[W-1] ? add_mod(dbl, a_reg, m) : dbl;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // MSB first over the multiplier
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- rtl/core/mexp_datapath.sv -----
// ----------------------------------------------------------------------------
// mexp_datapath
// Operand registers, modulus register, multiplier and output stage.
// ----------------------------------------------------------------------------
module mexp_datapath #(
    parameter int W = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [mexp_pkg::FIELD_W-1:0] cfg_data,
    input  logic [mexp_pkg::FIELD_W-1:0] in_base,
    input  logic [mexp_pkg::FIELD_W-1:0] in_exponent,
    input  logic                         out_ready,
    input  mexp_pkg::ctrl_cmd_t          cmd,
    output mexp_pkg::dp_status_t         status,
    output logic                         out_valid,
    output logic [mexp_pkg::FIELD_W-1:0] out_power
);

    logic [mexp_pkg::FIELD_W-1:0] modulus_reg;
    logic [mexp_pkg::FIELD_W-1:0] out_power_reg;
    logic                         out_valid_reg;
    logic [W-1:0]                 base_reg;
    logic [W-1:0]                 exp_reg;
    logic [W-1:0]                 res_reg;
    logic [W-1:0]                 sq_reg;
    logic [W-1:0]                 m_w;
    logic [W-1:0]                 op_a;
    logic [W-1:0]                 op_b;
    logic [W-1:0]                 product;
    logic                         mul_done;

    assign m_w = W'(modulus_reg);

    always_comb begin
        case (cmd.op)
            mexp_pkg::OP_REDUCE: begin
                op_a = W'(1);
                op_b = base_reg;
            end
            mexp_pkg::OP_MUL: begin
                op_a = res_reg;
                op_b = sq_reg;
            end
            default: begin
                op_a = sq_reg;
                op_b = sq_reg;
            end
        endcase
    end

    mexp_modmul #(.W(W)) u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .a       (op_a),
        .b       (op_b),
        .m       (m_w),
        .done    (mul_done),
        .product (product)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg   <= mexp_pkg::MODULUS_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                modulus_reg <= cfg_data;
            end
            if (cmd.publish) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            base_reg <= W'(in_base);
            exp_reg  <= W'(in_exponent);
            res_reg  <= W'(1);
        end else begin
            if (cmd.force_zero) begin
                res_reg <= '0;
            end else if (cmd.wb_res) begin
                res_reg <= product;
            end
            if (cmd.shift_exp) begin
                exp_reg <= exp_reg >> 1;
            end
        end
        if (cmd.wb_sq) begin
            sq_reg <= product;
        end
        if (cmd.publish) begin
            out_power_reg <= mexp_pkg::FIELD_W'(res_reg);
        end
    end

    assign status.m_small  = (m_w < W'(2));
    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_lsb  = exp_reg[0];
    assign status.mul_done = mul_done;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_power = out_power_reg;

endmodule

// ----- rtl/core/mexp_ctrl.sv -----
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
module mexp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mexp_pkg::dp_status_t status,
    output mexp_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_RED   = 7'b0000100,
        S_NEXT  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_SQR   = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.op     = mexp_pkg::OP_REDUCE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (status.m_small) begin
                    cmd.force_zero = 1'b1;
                    state_next     = S_FIN;
                end else if (status.exp_zero) begin
                    state_next = S_FIN;
                end else begin
                    cmd.start  = 1'b1;
                    cmd.op     = mexp_pkg::OP_REDUCE;
                    state_next = S_RED;
                end
            end
            S_RED: begin
                if (status.mul_done) begin
                    cmd.wb_sq  = 1'b1;
                    state_next = S_NEXT;
                end
            end
            S_NEXT: begin
                if (status.exp_zero) begin
                    state_next = S_FIN;
                end else if (status.exp_lsb) begin
                    cmd.start  = 1'b1;
                    cmd.op     = mexp_pkg::OP_MUL;
                    state_next = S_MUL;
                end else begin
                    cmd.start  = 1'b1;
                    cmd.op     = mexp_pkg::OP_SQR;
                    state_next = S_SQR;
                end
            end
            S_MUL: begin
                if (status.mul_done) begin
                    cmd.wb_res = 1'b1;
                    cmd.start  = 1'b1;
                    cmd.op     = mexp_pkg::OP_SQR;
                    state_next = S_SQR;
                end
            end
            S_SQR: begin
                cmd.op = mexp_pkg::OP_SQR;
                if (status.mul_done) begin
                    cmd.wb_sq     = 1'b1;
                    cmd.shift_exp = 1'b1;
                    state_next    = S_NEXT;
                end
            end
            S_FIN: begin
                if (status.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/modular_exponentiation_core.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Computes base ** exponent mod modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// One item at a time: a base and an exponent come in on the s_ channel and
// one power comes out on the m_ channel. The modulus is a register written
// over the cfg_ channel (reset value 1000000007); the user must change it
// only while no item is in flight, which the block itself does not enforce.
// A modulus below 2 gives 0; an exponent of 0 gives 1 for any base. Every
// modular product goes through one shared bit-serial shift-add multiplier
// of OPERAND_WIDTH (W) bits, and that multiplier sets the rate. An item
// passes through the transfer, the base reduction and setup, then for each
// exponent bit up to the highest set one a square, plus a multiply when the
// bit is set, and a finishing step. A trivial item (zero exponent or small
// modulus) skips the multiplier. The result sits in an output register, so
// the next item is taken as soon as the result is parked there.
// ----------------------------------------------------------------------------
module modular_exponentiation_core #(
    parameter int OPERAND_WIDTH = 32   // internal datapath width, 8..64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // modulus write
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mexp_pkg::FIELD_W-1:0] cfg_data,
    // input items
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [mexp_pkg::FIELD_W-1:0] s_base,
    input  logic [mexp_pkg::FIELD_W-1:0] s_exponent,
    // results
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [mexp_pkg::FIELD_W-1:0] m_power
);

    mexp_pkg::ctrl_cmd_t  cmd;
    mexp_pkg::dp_status_t status;

    // modulus writes are always taken; one transfer per cycle
    assign cfg_ready = 1'b1;

    // sequencer: walks the exponent bits, issues multiplies
    mexp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // operands, multiplier, modulus register, output register
    mexp_datapath #(.W(OPERAND_WIDTH)) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .in_base     (s_base),
        .in_exponent (s_exponent),
        .out_ready   (m_ready),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_valid),
        .out_power   (m_power)
    );

endmodule

// ----- rtl/core/mexp_checker.sv -----
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks of the modular exponentiation core, bound to the top.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_core_assert.svh"

module mexp_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic [mexp_pkg::FIELD_W-1:0] cfg_data,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic [mexp_pkg::FIELD_W-1:0] s_base,
    input logic [mexp_pkg::FIELD_W-1:0] s_exponent,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [mexp_pkg::FIELD_W-1:0] m_power
);

    // shadow copy of the modulus as seen on the config port
    logic [mexp_pkg::FIELD_W-1:0] mod_shadow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_shadow_reg <= mexp_pkg::MODULUS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            mod_shadow_reg <= cfg_data;
        end
    end

    `MEXP_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_power), "result dropped or changed while stalled")
    `MEXP_ASSERT(a_one_at_a_time, s_valid && s_ready |=> !s_ready, "input taken while an item is in flight")
    `MEXP_ASSERT(a_residue_range, m_valid && (mod_shadow_reg > 32'd1) |-> m_power < mod_shadow_reg, "power not reduced below modulus")
    `MEXP_ASSERT(a_small_modulus, m_valid && (mod_shadow_reg < 32'd2) |-> m_power == '0, "nonzero power with modulus below two")
    `MEXP_ASSERT_RST(a_reset_idle, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind modular_exponentiation_core mexp_checker u_checker (.*);
